### rtl/core/arc_pkg.sv
// Package with shared types, codes and constants for the address resolution cache.
`default_nettype none
package arc_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int KEY_W  = 32;
    localparam int MAC_W  = 48;
    localparam int LIFE_W = 16;
    localparam int TIME_W = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic [LIFE_W-1:0] DEFAULT_LIFETIME_RST = 16'd300;

    localparam logic REG_DEFAULT_LIFETIME = 1'b0;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_PUT_RESOLVED = 3'd0,
        OP_PUT_PENDING  = 3'd1,
        OP_GET          = 3'd2,
        OP_REMOVE       = 3'd3,
        OP_CLEAR        = 3'd4,
        OP_SWEEP        = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] expiry;
        logic              resolved;
    } entry_t;

endpackage
`default_nettype wire

### rtl/core/arc_entry_mem.sv
// Entry memory with one write port and one registered read port.
`default_nettype none
module arc_entry_mem
    import arc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire entry_t                     wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output entry_t                          rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/address_resolution_cache_with_expiry_core.sv
// Top level of the address resolution cache with expiry: sequencer, scan unit and ports.
//
// Channel   Direction  Handshake            Contents
// s_        in         s_tvalid / s_tready  one operation word
// m_        out        m_tvalid / m_tready  one result word per operation
// apb       in/out     psel / penable       default lifetime register
//
// Put, get, remove and sweep walk every entry through the one memory read port and the
// shared key and expiry comparator; clear and the unused modes go straight to the final
// step. Reset clears all valid bits and the entry count at once.
// A new word is taken while the previous result still waits in the output register; the
// sequencer holds in its final step until that register is free.
`default_nettype none
module address_resolution_cache_with_expiry_core
    import arc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ip_address[31:0], mac_address[79:32], lifetime[95:80], current_time[127:96]
    input  wire logic [127:0] s_tdata,
    // mode[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], found[2], is_resolved[3], found_mac[51:4], entry_count[56:52], zero
    output logic [63:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;

    logic [2:0]        mode_reg;
    logic [KEY_W-1:0]  ip_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [LIFE_W-1:0] life_reg;
    logic [TIME_W-1:0] now_reg;

    logic              match_reg, match_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [MAC_W-1:0]  hit_mac_reg, hit_mac_next;
    logic              hit_res_reg, hit_res_next;
    logic [TIME_W-1:0] hit_exp_reg, hit_exp_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIFE_W-1:0]  dflt_life_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_res_reg, out_res_next;
    logic [MAC_W-1:0]     out_mac_reg, out_mac_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;

    logic       accept;
    logic       scan_issue;
    logic       fin_go;
    logic       cfg_wr;
    logic       mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t     mem_wr_data;
    entry_t     rd_entry;

    logic              key_eq;
    logic              expired;
    logic [LIFE_W-1:0] life_sel;
    logic [TIME_W:0]   exp_sum;
    logic [TIME_W-1:0] exp_sat;

    arc_entry_mem #(
        .ENTRIES(ENTRIES)
    ) u_entry_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (scan_issue),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DEFAULT_LIFETIME) ? {16'd0, dflt_life_reg} : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_cnt_reg, out_mac_reg, out_res_reg, out_found_reg,
                       out_status_reg};

    // Shared comparator and expiry adder.
    assign key_eq   = valid_reg[cmp_idx_reg] && (rd_entry.key == ip_reg);
    assign expired  = now_reg > rd_entry.expiry;
    assign life_sel = (mode_reg == OP_PUT_RESOLVED && life_reg == '0) ? dflt_life_reg
                                                                       : life_reg;
    assign exp_sum  = {1'b0, now_reg} + {{(TIME_W + 1 - LIFE_W){1'b0}}, life_sel};
    assign exp_sat  = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_PUT_RESOLVED || s_tuser == OP_PUT_PENDING ||
                        s_tuser == OP_GET || s_tuser == OP_REMOVE ||
                        s_tuser == OP_SWEEP) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg == CNT_W'(ENTRIES)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        scan_issue = 1'b0;
        fin_go     = 1'b0;
        case (state_reg)
            ST_SCAN: begin
                scan_issue = (idx_reg < CNT_W'(ENTRIES));
            end
            ST_FINISH: begin
                fin_go = !m_tvalid_reg || m_tready;
            end
            default: begin
                scan_issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

        cnt_ext         = '0;
        idx_next        = idx_reg;
        cmp_vld_next    = scan_issue;
        cmp_idx_next    = idx_reg[IDX_W-1:0];
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        hit_mac_next    = hit_mac_reg;
        hit_res_next    = hit_res_reg;
        hit_exp_next    = hit_exp_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_res_next    = out_res_reg;
        out_mac_next    = out_mac_reg;
        out_cnt_next    = out_cnt_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = free_idx_reg;
        mem_wr_data.key      = ip_reg;
        mem_wr_data.mac      = (mode_reg == OP_PUT_RESOLVED) ? mac_reg : '0;
        mem_wr_data.expiry   = exp_sat;
        mem_wr_data.resolved = (mode_reg == OP_PUT_RESOLVED);

        if (accept) begin
            idx_next   = '0;
            match_next = 1'b0;
            free_next  = 1'b0;
        end

        if (scan_issue) begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmp_vld_reg) begin
            if (key_eq && !match_reg) begin
                match_next     = 1'b1;
                match_idx_next = cmp_idx_reg;
                hit_mac_next   = rd_entry.mac;
                hit_res_next   = rd_entry.resolved;
                hit_exp_next   = rd_entry.expiry;
            end
            if (!valid_reg[cmp_idx_reg] && !free_reg) begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
            if (mode_reg == OP_SWEEP && valid_reg[cmp_idx_reg] && expired) begin
                valid_next[cmp_idx_reg] = 1'b0;
                count_next              = count_reg - 1'b1;
            end
        end

        if (fin_go) begin
            out_status_next = STATUS_OK;
            out_found_next  = 1'b0;
            out_res_next    = 1'b0;
            out_mac_next    = '0;
            m_tvalid_next   = 1'b1;
            case (mode_reg)
                OP_PUT_RESOLVED, OP_PUT_PENDING: begin
                    if (match_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = match_idx_reg;
                    end else if (free_reg) begin
                        mem_wr_en                = 1'b1;
                        mem_wr_addr              = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                        count_next               = count_reg + 1'b1;
                    end else begin
                        out_status_next = STATUS_FULL;
                    end
                end
                OP_GET: begin
                    if (match_reg && now_reg <= hit_exp_reg) begin
                        out_found_next = 1'b1;
                        out_res_next   = hit_res_reg;
                        out_mac_next   = hit_mac_reg;
                    end else begin
                        out_status_next = STATUS_MISS;
                    end
                end
                OP_REMOVE: begin
                    if (match_reg) begin
                        valid_next[match_idx_reg] = 1'b0;
                        count_next                = count_reg - 1'b1;
                    end
                end
                OP_CLEAR: begin
                    valid_next = '0;
                    count_next = '0;
                end
                default: begin
                    out_status_next = STATUS_OK;
                end
            endcase
            cnt_ext      = {{CNT_OUT_W{1'b0}}, count_next};
            out_cnt_next = cnt_ext[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            dflt_life_reg <= DEFAULT_LIFETIME_RST;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            match_reg    <= match_next;
            free_reg     <= free_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr && paddr[2] == REG_DEFAULT_LIFETIME) begin
                dflt_life_reg <= pwdata[LIFE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_tuser;
            ip_reg   <= s_tdata[31:0];
            mac_reg  <= s_tdata[79:32];
            life_reg <= s_tdata[95:80];
            now_reg  <= s_tdata[127:96];
        end
        cmp_idx_reg    <= cmp_idx_next;
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        hit_mac_reg    <= hit_mac_next;
        hit_res_reg    <= hit_res_next;
        hit_exp_reg    <= hit_exp_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_res_reg    <= out_res_next;
        out_mac_reg    <= out_mac_next;
        out_cnt_reg    <= out_cnt_next;
    end

endmodule
`default_nettype wire
